@@ design/lspd_pkg.sv @@
`default_nettype none

package lspd_pkg;

  // Stack depth and time counter width
  localparam int MAX_LEVEL = 64;
  localparam int TIME_BITS = 16;

  // Internal widths: level count must hold MAX_LEVEL itself, address indexes the stack
  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int ADDR_W = $clog2(MAX_LEVEL);

  // Fixed field widths of the channel words
  localparam int FIELD_TIME_W = 16;
  localparam int FIELD_LVL_W  = 7;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [FIELD_LVL_W-1:0] sample_level;
  } item_t;

  typedef struct packed {
    logic [FIELD_TIME_W-1:0] pulse_start;
    logic [FIELD_TIME_W-1:0] pulse_end;
    logic [FIELD_LVL_W-1:0]  pulse_level;
    logic                    last;
  } pulse_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic   valid;
    pulse_t word;
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PRIME,
    ST_POP
  } state_t;

  // Clamp a sample level to the stack depth
  function automatic logic [LVL_W-1:0] clamp_level(input logic [FIELD_LVL_W-1:0] lv);
    logic [31:0] lv32;
    lv32 = 32'(lv);
    if (lv32 > 32'(MAX_LEVEL)) begin
      return LVL_W'(MAX_LEVEL);
    end
    return LVL_W'(lv32);
  endfunction

endpackage

`default_nettype wire

@@ design/lspd_ram.sv @@
`default_nettype none

module lspd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/lspd_seq.sv @@
`default_nettype none

module lspd_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire lspd_pkg::item_t               in_word,
  output logic                               in_stall,
  input  wire logic                          out_free,
  output lspd_pkg::emit_t                    emit,
  output logic                               ram_we,
  output logic [lspd_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [lspd_pkg::TIME_BITS-1:0]     ram_wdata,
  output logic [lspd_pkg::ADDR_W-1:0]        ram_raddr,
  input  wire logic [lspd_pkg::TIME_BITS-1:0] ram_rdata
);

  lspd_pkg::state_t                  state_r, state_nxt;
  logic [lspd_pkg::LVL_W-1:0]        cur_r, cur_nxt;
  logic [lspd_pkg::LVL_W-1:0]        target_r, target_nxt;
  logic [lspd_pkg::TIME_BITS-1:0]    time_r, time_nxt;
  logic                              flush_r, flush_nxt;

  logic [lspd_pkg::LVL_W-1:0]        cur_dec;
  logic [lspd_pkg::LVL_W-1:0]        cur_dec2;
  logic [lspd_pkg::LVL_W-1:0]        cur_inc;
  logic [lspd_pkg::LVL_W-1:0]        in_target;
  logic                              finish;
  logic                              fin_flush;
  logic                              pop_last;

  assign cur_dec   = cur_r - lspd_pkg::LVL_W'(1);
  assign cur_dec2  = cur_r - lspd_pkg::LVL_W'(2);
  assign cur_inc   = cur_r + lspd_pkg::LVL_W'(1);
  assign in_target = (in_word.cmd == lspd_pkg::CMD_FLUSH) ? '0 :
                     lspd_pkg::clamp_level(in_word.sample_level);
  assign pop_last  = (cur_dec == target_r);
  assign in_stall  = (state_r != lspd_pkg::ST_IDLE);
  assign ram_wdata = time_r;

  // State register and item context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lspd_pkg::ST_IDLE;
      cur_r   <= '0;
      time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      time_r  <= time_nxt;
    end
    target_r <= target_nxt;
    flush_r  <= flush_nxt;
  end

  // Sequence pushes and pops, one stack access per cycle
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    time_nxt   = time_r;
    target_nxt = target_r;
    flush_nxt  = flush_r;
    finish     = 1'b0;
    fin_flush  = flush_r;
    ram_we     = 1'b0;
    ram_waddr  = cur_r[lspd_pkg::ADDR_W-1:0];
    ram_raddr  = cur_dec[lspd_pkg::ADDR_W-1:0];
    emit       = '0;

    unique case (state_r)
      lspd_pkg::ST_IDLE: begin
        if (in_valid) begin
          target_nxt = in_target;
          flush_nxt  = in_word.cmd;
          fin_flush  = in_word.cmd;
          if (in_target > cur_r) begin
            state_nxt = lspd_pkg::ST_PUSH;
          end else if (in_target < cur_r) begin
            state_nxt = lspd_pkg::ST_PRIME;
          end else begin
            finish = 1'b1;
          end
        end
      end
      lspd_pkg::ST_PUSH: begin
        ram_we  = 1'b1;
        cur_nxt = cur_inc;
        if (cur_inc == target_r) begin
          finish    = 1'b1;
          state_nxt = lspd_pkg::ST_IDLE;
        end
      end
      lspd_pkg::ST_PRIME: begin
        state_nxt = lspd_pkg::ST_POP;
      end
      lspd_pkg::ST_POP: begin
        emit.valid            = out_free;
        emit.word.pulse_start = lspd_pkg::FIELD_TIME_W'(ram_rdata);
        emit.word.pulse_end   = lspd_pkg::FIELD_TIME_W'(time_r);
        emit.word.pulse_level = lspd_pkg::FIELD_LVL_W'(cur_r);
        emit.word.last        = pop_last;
        if (out_free) begin
          cur_nxt = cur_dec;
          if (pop_last) begin
            finish    = 1'b1;
            state_nxt = lspd_pkg::ST_IDLE;
          end else begin
            // prefetch the next entry down
            ram_raddr = cur_dec2[lspd_pkg::ADDR_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = lspd_pkg::ST_IDLE;
      end
    endcase

    // Close the item: clear on flush, else advance the saturating time
    if (finish) begin
      if (fin_flush) begin
        time_nxt = '0;
        cur_nxt  = '0;
      end else if (time_r != lspd_pkg::TIME_MAX) begin
        time_nxt = time_r + lspd_pkg::TIME_BITS'(1);
      end
    end
  end

  a_pop_above_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lspd_pkg::ST_POP) |-> (cur_r > target_r))
    else $error("pop with stack at or below target");

  a_push_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lspd_pkg::ST_PUSH) |-> (cur_r < target_r))
    else $error("push with stack at or above target");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && fin_flush) |=> (time_r == '0 && cur_r == '0 && state_r == lspd_pkg::ST_IDLE))
    else $error("flush did not clear time and level");

  a_emit_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (state_r == lspd_pkg::ST_POP && out_free))
    else $error("result emitted outside pop or into a full register");

endmodule

`default_nettype wire

@@ design/level_signal_pulse_decomposer_unit.sv @@
`default_nettype none

// Staircase level signal to stacked pulses.
// Input channel (in_valid / in_stall / in_word): one word per time step. A sample
// word carries the level of that step; a flush word ends the signal.
// Output channel (out_valid / out_stall / out_word): one word per level unit lost,
// top unit first, with last set on the final pulse caused by one input word.
// The start-time stack is a single RAM with one access per cycle.
//   An unchanged level finishes on acceptance; a rise by k units takes one push
//   per unit. A fall or flush of k units passes a prime state, then one pop per
//   unit; each pulse goes to the output register, and pops hold while it is full.
//   Worst case is a full swing of 64 units.
// The block takes no new input word until the current one is finished.
// A pulse waits in the output register while out_stall is high, and the pop
// sequence holds; no pulse is lost or repeated.
// Reset clears the level and the time counter; the stack needs no clearing
// since only entries below the current level are read.
module level_signal_pulse_decomposer_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lspd_pkg::item_t  in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lspd_pkg::pulse_t      out_word
);

  lspd_pkg::emit_t                 emit;
  logic                            out_free;
  logic                            out_valid_r;
  lspd_pkg::pulse_t                out_word_r;
  logic                            ram_we;
  logic [lspd_pkg::ADDR_W-1:0]     ram_waddr;
  logic [lspd_pkg::TIME_BITS-1:0]  ram_wdata;
  logic [lspd_pkg::ADDR_W-1:0]     ram_raddr;
  logic [lspd_pkg::TIME_BITS-1:0]  ram_rdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  lspd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lspd_ram #(
    .WIDTH (lspd_pkg::TIME_BITS),
    .DEPTH (lspd_pkg::MAX_LEVEL)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit.valid) begin
      out_word_r <= emit.word;
    end
  end

endmodule

`default_nettype wire
